// ===== hdl/imu_cal_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_cal_pkg: shared types and constants
// Constants, CORDIC angle table and sequencer states for the IMU calibration
// and Euler conversion block.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

  localparam int unsigned CalPollsDefault = 100;
  localparam int unsigned CordicSteps     = 16;
  localparam logic signed [15:0] GravityQ88 = 16'sd2509;
  localparam logic signed [19:0] HalfPiQ16  = 20'sd102944;

  // atan2 datapath width: operands reach about 2^32 in magnitude, gain 1.65
  localparam int unsigned CW = 36;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_QUAT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ATAN_R,
    ST_SQRT,
    ST_ATAN_P,
    ST_ATAN_Y,
    ST_APPLY,
    ST_DIV,
    ST_OUT
  } state_e;

  function automatic logic signed [19:0] atan_entry(input logic [3:0] i);
    logic signed [19:0] r;
    case (i)
      4'd0:    r = 20'sd51472;
      4'd1:    r = 20'sd30386;
      4'd2:    r = 20'sd16055;
      4'd3:    r = 20'sd8150;
      4'd4:    r = 20'sd4091;
      4'd5:    r = 20'sd2047;
      4'd6:    r = 20'sd1024;
      4'd7:    r = 20'sd512;
      4'd8:    r = 20'sd256;
      4'd9:    r = 20'sd128;
      4'd10:   r = 20'sd64;
      4'd11:   r = 20'sd32;
      4'd12:   r = 20'sd16;
      4'd13:   r = 20'sd8;
      4'd14:   r = 20'sd4;
      default: r = 20'sd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hdl/imu_cal_cordic.sv =====
// ----------------------------------------------------------------------------
// imu_cal_cordic: iterative atan2
// Vectoring CORDIC, one step per cycle, 16 steps, result Q3.12 radians.
// ----------------------------------------------------------------------------
module imu_cal_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [imu_cal_pkg::CW-1:0]   y_i,
  input  logic signed [imu_cal_pkg::CW-1:0]   x_i,
  output logic                                done_o,
  output logic signed [15:0]                  angle_o
);
  import imu_cal_pkg::*;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [20:0]   z_q, z_d;
  logic [3:0]           i_q, i_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic signed [20:0]   zr;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      if (x_i == '0 && y_i == '0) begin
        x_d = '0; y_d = '0; z_d = '0; done_d = 1'b1;
      end else begin
        busy_d = 1'b1; i_d = '0;
        if (x_i < 0 && y_i >= 0) begin
          x_d = y_i; y_d = -x_i; z_d = 21'(HalfPiQ16);
        end else if (x_i < 0) begin
          x_d = -y_i; y_d = x_i; z_d = -21'(HalfPiQ16);
        end else begin
          x_d = x_i; y_d = y_i; z_d = '0;
        end
      end
    end else if (busy_q) begin
      // arithmetic shifts are floor shifts
      if (y_q >= 0) begin
        x_d = x_q + (y_q >>> i_q);
        y_d = y_q - (x_q >>> i_q);
        z_d = z_q + 21'(atan_entry(i_q));
      end else begin
        x_d = x_q - (y_q >>> i_q);
        y_d = y_q + (x_q >>> i_q);
        z_d = z_q - 21'(atan_entry(i_q));
      end
      i_d = i_q + 4'd1;
      if (i_q == 4'(CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      z_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      z_q    <= z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    i_q <= i_d;
  end

  assign zr      = (z_q + 21'sd8) >>> 4;
  assign done_o  = done_q;
  assign angle_o = zr[15:0];

endmodule

// ===== hdl/imu_offset_calibration_euler_unit.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibration_euler_unit: IMU bias calibration and Euler angles
// Accumulates per-axis offsets over calibration polls and emits corrected
// accel, rate and quaternion-derived roll/pitch/yaw on measurement polls.
// ----------------------------------------------------------------------------
// One poll is taken at a time; in_ready_o is low until its work is done.
// An accel or rate poll is accepted and then passes through the apply state. A
// quaternion poll runs one shared multiplier over nine products, a square
// root that forms one minus the squared sine and then takes 29 bit steps,
// and three 16-step CORDIC passes on one shared atan2 unit (a zero vector
// skips the steps), all before the apply state. The poll that closes a
// calibration run adds nine offset divisions by CALIBRATION_POLLS, each by
// a reciprocal multiplication. No result comes from calibration polls; a
// measurement poll with a valid event gives one, and the block stays busy
// until that item is taken.
module imu_offset_calibration_euler_unit #(
  parameter int unsigned CALIBRATION_POLLS = imu_cal_pkg::CalPollsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic               event_valid_i,
  input  logic [1:0]         report_kind_i,
  input  logic signed [15:0] comp_real_i,
  input  logic signed [15:0] comp_x_i,
  input  logic signed [15:0] comp_y_i,
  input  logic signed [15:0] comp_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] accel_x_o,
  output logic signed [15:0] accel_y_o,
  output logic signed [15:0] accel_z_o,
  output logic signed [15:0] rate_x_o,
  output logic signed [15:0] rate_y_o,
  output logic signed [15:0] rate_z_o,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o,
  output logic signed [15:0] yaw_o,
  output logic               offsets_valid_o
);
  import imu_cal_pkg::*;

  localparam int unsigned CntW = $clog2(CALIBRATION_POLLS + 1);
  localparam int unsigned SumW = 16 + CntW + 1;
  // divide by reciprocal: q = (|sum| * ceil(2^RecK / N)) >> RecK, exact for |sum| < 2^MagW
  localparam int unsigned MagW = SumW - 1;
  localparam int unsigned RecK = MagW + CntW;
  localparam int unsigned RecW = MagW + 2;
  localparam longint unsigned RecipL =
    ((64'd1 << RecK) + 64'(CALIBRATION_POLLS) - 64'd1) / 64'(CALIBRATION_POLLS);
  localparam logic [RecW-1:0] RecipC = RecW'(RecipL);

  state_e state_q, state_d;

  logic                 act_q, ev_q;
  logic [1:0]           kind_q;
  logic signed [15:0]   qw_q, qx_q, qy_q, qz_q;

  logic signed [15:0]   offs_q [9];
  logic signed [SumW-1:0] sums_q [9];
  logic signed [15:0]   held_q [9];
  logic [CntW-1:0]      cnt_q;
  logic                 calib_q;
  logic signed [15:0]   v_q [3];

  // shared multiplier
  logic [3:0]           mstep_q;
  logic signed [15:0]   ma, mb;
  logic signed [31:0]   prod;
  logic signed [31:0]   p_q [9];

  // square root
  logic [57:0]          sq_rem_q;
  logic [57:0]          sq_root_q;
  logic [57:0]          sq_bit_q;
  logic [4:0]           sq_i_q;
  logic signed [CW-1:0] s_q;

  // divider
  logic [3:0]           dax_q;
  logic [1:0]           dstep_q;
  logic [MagW-1:0]      dnum_q;
  logic [MagW+RecW-1:0] dprod_q;
  logic                 dneg_q;
  logic [16:0]          dquo;
  logic signed [39:0]   dofs;

  logic                 cord_start, cord_done;
  logic signed [CW-1:0] cy, cx;
  logic signed [15:0]   cang;
  logic [1:0]           ang_i;

  logic in_fire, out_fire;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_fire   = out_valid_o && out_ready_i;

  // multiplier operand select, products in order
  // 0 wx 1 yz 2 xx 3 yy 4 wy 5 zx 6 wz 7 xy 8 zz
  always_comb begin
    case (mstep_q)
      4'd0:    begin ma = qw_q; mb = qx_q; end
      4'd1:    begin ma = qy_q; mb = qz_q; end
      4'd2:    begin ma = qx_q; mb = qx_q; end
      4'd3:    begin ma = qy_q; mb = qy_q; end
      4'd4:    begin ma = qw_q; mb = qy_q; end
      4'd5:    begin ma = qz_q; mb = qx_q; end
      4'd6:    begin ma = qw_q; mb = qz_q; end
      4'd7:    begin ma = qx_q; mb = qy_q; end
      default: begin ma = qz_q; mb = qz_q; end
    endcase
  end
  assign prod = ma * mb;

  localparam logic signed [CW-1:0] OneQ28 = CW'(64'sd268435456);

  logic signed [CW-1:0] s_raw, s_clamp;
  assign s_raw = CW'(p_q[4]) * 2 - CW'(p_q[5]) * 2;
  assign s_clamp = (s_raw > OneQ28) ? OneQ28 : ((s_raw < -OneQ28) ? -OneQ28 : s_raw);

  always_comb begin
    case (state_q)
      ST_ATAN_R: begin
        cy = (CW'(p_q[0]) + CW'(p_q[1])) * 2;
        cx = OneQ28 - (CW'(p_q[2]) + CW'(p_q[3])) * 2;
      end
      ST_ATAN_P: begin
        cy = s_q;
        cx = CW'({1'b0, sq_root_q[28:0]});
      end
      default: begin
        cy = (CW'(p_q[6]) + CW'(p_q[7])) * 2;
        cx = OneQ28 - (CW'(p_q[3]) + CW'(p_q[8])) * 2;
      end
    endcase
  end

  logic cstarted_q;
  assign cord_start = !cstarted_q &&
                      (state_q == ST_ATAN_R || state_q == ST_ATAN_P || state_q == ST_ATAN_Y);

  imu_cal_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .y_i     (cy),
    .x_i     (cx),
    .done_o  (cord_done),
    .angle_o (cang)
  );

  logic has_rep;
  assign has_rep = ev_q && (kind_q != KIND_NONE);
  logic cnt_last;
  assign cnt_last = ({1'b0, cnt_q} + 1'b1) >= (CntW + 1)'(CALIBRATION_POLLS);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) begin
        if (event_valid_i && report_kind_i == KIND_QUAT) state_d = ST_MUL;
        else state_d = ST_APPLY;
      end
      ST_MUL:    if (mstep_q == 4'd8) state_d = ST_ATAN_R;
      ST_ATAN_R: if (cord_done) state_d = ST_SQRT;
      ST_SQRT:   if (sq_i_q == 5'd29) state_d = ST_ATAN_P;
      ST_ATAN_P: if (cord_done) state_d = ST_ATAN_Y;
      ST_ATAN_Y: if (cord_done) state_d = ST_APPLY;
      ST_APPLY: begin
        if (!act_q) state_d = cnt_last ? ST_DIV : ST_IDLE;
        else state_d = ev_q ? ST_OUT : ST_IDLE;
      end
      ST_DIV: if (dstep_q == 2'd2 && dax_q == 4'd8) state_d = ST_IDLE;
      ST_OUT: if (out_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // datapath registers, driven by the sequencer state
  logic [28:0] s_mag;
  logic [57:0] s_sq;
  logic [57:0] sq_try;
  assign s_mag  = 29'(s_q[CW-1] ? -s_q : s_q);
  assign s_sq   = s_mag * s_mag;
  assign sq_try = sq_root_q + sq_bit_q;

  assign dquo = dprod_q[RecK +: 17];
  assign dofs = (dneg_q ? -40'($signed({1'b0, dquo})) : 40'($signed({1'b0, dquo})))
                - ((dax_q == 4'd2) ? 40'(GravityQ88) : 40'sd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      calib_q    <= 1'b0;
      cstarted_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        offs_q[i] <= '0;
        sums_q[i] <= '0;
        held_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_ATAN_R, ST_ATAN_P, ST_ATAN_Y: begin
          cstarted_q <= !cord_done;
        end
        ST_APPLY: begin
          if (!act_q) begin
            if (has_rep)
              for (int i = 0; i < 3; i++)
                sums_q[kind_q*3+i] <= sums_q[kind_q*3+i] + SumW'(v_q[i]);
            cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
          end else if (has_rep) begin
            for (int i = 0; i < 3; i++)
              held_q[kind_q*3+i] <= sat16(40'(v_q[i]) - 40'(offs_q[kind_q*3+i]));
          end
        end
        ST_DIV: begin
          if (dstep_q == 2'd2) begin
            offs_q[dax_q] <= sat16(dofs);
            sums_q[dax_q] <= '0;
            if (dax_q == 4'd8) calib_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        act_q <= action_i; ev_q <= event_valid_i; kind_q <= report_kind_i;
        qw_q <= comp_real_i; qx_q <= comp_x_i; qy_q <= comp_y_i; qz_q <= comp_z_i;
        v_q[0] <= comp_x_i; v_q[1] <= comp_y_i; v_q[2] <= comp_z_i;
        mstep_q <= '0;
      end
      ST_MUL: begin
        p_q[mstep_q] <= prod;
        mstep_q <= mstep_q + 4'd1;
        sq_i_q <= '0;
        sq_root_q <= '0;
      end
      ST_ATAN_R: begin
        if (cord_done) v_q[0] <= cang;
        s_q <= s_clamp;
        sq_rem_q <= 58'd1 << 56;
        sq_bit_q <= 58'd1 << 56;
        sq_i_q <= '0;
        sq_root_q <= '0;
      end
      ST_SQRT: begin
        // first cycle forms 1 - s^2, then one bit of the root per cycle
        if (sq_i_q == 5'd0) begin
          sq_rem_q <= sq_rem_q - s_sq;
        end else begin
          if (sq_rem_q >= sq_try) begin
            sq_rem_q  <= sq_rem_q - sq_try;
            sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
          end else begin
            sq_root_q <= sq_root_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
        end
        sq_i_q <= sq_i_q + 5'd1;
      end
      ST_ATAN_P: if (cord_done) v_q[1] <= cang;
      ST_ATAN_Y: if (cord_done) v_q[2] <= cang;
      ST_APPLY: begin
        dax_q <= '0; dstep_q <= '0;
      end
      ST_DIV: begin
        // per axis: take magnitude, multiply by reciprocal, write offset (less gravity for accel z)
        if (dstep_q == 2'd0) begin
          dneg_q <= sums_q[dax_q][SumW-1];
          dnum_q <= MagW'(sums_q[dax_q][SumW-1] ? -sums_q[dax_q] : sums_q[dax_q]);
          dstep_q <= 2'd1;
        end else if (dstep_q == 2'd1) begin
          dprod_q <= dnum_q * RecipC;
          dstep_q <= 2'd2;
        end else begin
          dax_q <= dax_q + 4'd1; dstep_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign ang_i = 2'd0;
  assign accel_x_o = held_q[0];
  assign accel_y_o = held_q[1];
  assign accel_z_o = held_q[2];
  assign rate_x_o  = held_q[3];
  assign rate_y_o  = held_q[4];
  assign rate_z_o  = held_q[5];
  assign roll_o    = held_q[6 + ang_i];
  assign pitch_o   = held_q[7];
  assign yaw_o     = held_q[8];
  assign offsets_valid_o = calib_q;

endmodule

// ===== hdl/imu_cal_checker.sv =====
// ----------------------------------------------------------------------------
// imu_cal_checker: port-level checks
// Watches the top level's handshakes over time.
// ----------------------------------------------------------------------------
module imu_cal_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic offsets_valid_o,
  input logic signed [15:0] roll_o
);
  // no new item while a result waits
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(roll_o))
    else $error("result dropped or changed");

  // offsets_valid never falls
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offsets_valid_o |=> offsets_valid_o) else $error("offsets_valid fell");

  // ready is low in the cycle after an item is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready right after accept");
endmodule

bind imu_offset_calibration_euler_unit imu_cal_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .offsets_valid_o (offsets_valid_o),
  .roll_o          (roll_o)
);
